### hw/rtl/ckbc_pkg.sv
`timescale 1ns / 1ps
package ckbc_pkg;

	localparam int LCG_W   = 45;
	localparam int MULT_W  = 9;
	localparam int WORD_W  = 32;
	localparam int SEED_W  = 64;
	localparam int BYTE_W  = 8;
	localparam int ADD_W   = 44;
	localparam int MULK_W  = 6;
	localparam int ROOT_W  = 7;
	localparam int CFG_A_W = 3;
	localparam int ROOT_MOD = 257;
	localparam int ROOT_N   = 128;

	// Input kind carried on s_tuser
	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_CHAIN_KEY    = 3'd0,
		CFG_ROOT_INDEX   = 3'd1,
		CFG_MUL_KEY      = 3'd2,
		CFG_ADD_KEY      = 3'd3,
		CFG_DECRYPT_MODE = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_SUM,
		ST_SEED_FOLD,
		ST_MUL,
		ST_RED,
		ST_MUL_AGAIN,
		ST_RED_AGAIN,
		ST_WORD_BYTE
	} ctrl_state_t;

	typedef struct packed {
		logic load_in;
		logic seed_sum;
		logic seed_fold;
		logic mul;
		logic red_lcg;
		logic red_mult;
		logic make_word;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_refill;
		logic red_is_one;
		logic out_free;
	} dp_status_t;

	// g = 3^(2i+1) mod 257, built at elaboration
	typedef logic [MULT_W-1:0] root_tbl_t [ROOT_N];

	function automatic root_tbl_t build_root_tbl();
		root_tbl_t t;
		int unsigned v;
		v = 3;
		for (int i = 0; i < ROOT_N; i++) begin
			t[i] = MULT_W'(v);
			v = (v * 9) % ROOT_MOD;
		end
		return t;
	endfunction

	localparam root_tbl_t ROOT_TBL = build_root_tbl();

endpackage

### hw/rtl/ckbc_ctrl.sv
`timescale 1ns / 1ps
module ckbc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tuser,
	output logic                  s_tready,
	input  ckbc_pkg::dp_status_t  status,
	output ckbc_pkg::dp_cmd_t     cmd
);
	import ckbc_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					if (s_tuser == CMD_SEED) begin
						state_d = ST_SEED_SUM;
					end else if (status.need_refill) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_WORD_BYTE;
					end
				end
			end
			ST_SEED_SUM: begin
				cmd.seed_sum = 1'b1;
				state_d      = ST_SEED_FOLD;
			end
			ST_SEED_FOLD: begin
				cmd.seed_fold = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RED;
			end
			ST_RED: begin
				cmd.red_lcg  = 1'b1;
				cmd.red_mult = 1'b1;
				state_d      = status.red_is_one ? ST_MUL_AGAIN : ST_WORD_BYTE;
				cmd.make_word = 1'b0;
			end
			ST_MUL_AGAIN: begin
				cmd.mul = 1'b1;
				state_d = ST_RED_AGAIN;
			end
			ST_RED_AGAIN: begin
				cmd.red_mult = 1'b1;
				state_d      = ST_WORD_BYTE;
			end
			ST_WORD_BYTE: begin
				// key word is rebuilt first when the buffer ran dry
				if (status.need_refill) begin
					cmd.make_word = 1'b1;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/ckbc_dp.sv
`timescale 1ns / 1ps
module ckbc_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ckbc_pkg::CFG_A_W-1:0]    cfg_addr,
	input  logic [ckbc_pkg::ADD_W-1:0]      cfg_wdata,
	input  logic [ckbc_pkg::SEED_W-1:0]     seed,
	input  logic [ckbc_pkg::BYTE_W-1:0]     data_in,
	input  ckbc_pkg::dp_cmd_t               cmd,
	output ckbc_pkg::dp_status_t            status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ckbc_pkg::BYTE_W-1:0]     data_out
);
	import ckbc_pkg::*;

	// configuration
	logic [BYTE_W-1:0] chain_key_q;
	logic [ROOT_W-1:0] root_index_q;
	logic [MULK_W-1:0] mul_key_q;
	logic [ADD_W-1:0]  add_key_q;
	logic              decrypt_q;

	// captured transaction
	logic [SEED_W-1:0] seed_q;
	logic [BYTE_W-1:0] din_q;
	logic [MULT_W-1:0] g_q;

	// generator state
	logic [LCG_W-1:0]  lcg_q;
	logic [MULT_W-1:0] mult_q;
	logic [WORD_W-1:0] key_word_q;
	logic [2:0]        bytes_left_q;
	logic [BYTE_W-1:0] chain_q;

	logic [10:0]         sum_q;
	logic [LCG_W-1:0]    lcg_prod_q;
	logic [2*MULT_W-2:0] mprod_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] data_out_q;

	// byte sum of the seed, 2^8 = 1 mod 255
	logic [10:0] byte_sum;
	always_comb begin
		byte_sum = '0;
		for (int i = 0; i < SEED_W / BYTE_W; i++) begin
			byte_sum = byte_sum + 11'(seed_q[i*BYTE_W +: BYTE_W]);
		end
	end

	logic [8:0] fold;
	logic [8:0] seed_mod;
	assign fold     = {1'b0, sum_q[7:0]} + {6'd0, sum_q[10:8]};
	assign seed_mod = (fold >= 9'd255) ? (fold - 9'd255) : fold;

	// x mod 257 with 256 = -1: lo - hi, plus 257 when negative
	logic [9:0]        mdiff;
	logic [MULT_W-1:0] mred;
	assign mdiff = {2'b00, mprod_q[7:0]} - {1'b0, mprod_q[16:8]};
	assign mred  = mdiff[9] ? 9'(mdiff + 10'd257) : mdiff[8:0];

	// keystream word from lcg and mult
	logic [4:0]        rot_r;
	logic [3:0]        rot_s;
	logic [5:0]        hi_sh;
	logic [LCG_W-1:0]  hi_full;
	logic [13:0]       s_mask;
	logic [12:0]       lo_bits;
	logic [WORD_W-1:0] lo_word;
	logic [WORD_W-1:0] word;
	assign rot_r   = mult_q[4:0];
	assign rot_s   = 4'd13 - mult_q[8:5];
	assign hi_sh   = {2'b00, rot_s} + {1'b0, rot_r};
	assign hi_full = lcg_q >> hi_sh;
	assign s_mask  = (14'd1 << rot_s) - 14'd1;
	assign lo_bits = lcg_q[12:0] & s_mask[12:0];
	assign lo_word = {19'd0, lo_bits} << (6'd32 - {2'b00, rot_s});
	assign word    = hi_full[WORD_W-1:0] + lo_word;

	// byte step
	logic [2:0]        bl_dec;
	logic [BYTE_W-1:0] ks;
	logic [BYTE_W-1:0] res;
	assign bl_dec = bytes_left_q - 3'd1;
	assign ks     = key_word_q[{bl_dec[1:0], 3'b000} +: BYTE_W];
	assign res    = decrypt_q ? (din_q + ks + chain_q) : (din_q - (ks + chain_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_key_q  <= '0;
			root_index_q <= '0;
			mul_key_q    <= '0;
			add_key_q    <= '0;
			decrypt_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CHAIN_KEY:    chain_key_q  <= cfg_wdata[BYTE_W-1:0];
				CFG_ROOT_INDEX:   root_index_q <= cfg_wdata[ROOT_W-1:0];
				CFG_MUL_KEY:      mul_key_q    <= cfg_wdata[MULK_W-1:0];
				CFG_ADD_KEY:      add_key_q    <= cfg_wdata;
				CFG_DECRYPT_MODE: decrypt_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			seed_q <= seed;
			din_q  <= data_in;
			g_q    <= ROOT_TBL[root_index_q];
		end
		if (cmd.seed_sum) begin
			sum_q <= byte_sum;
		end
		if (cmd.mul) begin
			lcg_prod_q <= LCG_W'(lcg_q * {mul_key_q, 2'b01});
			mprod_q    <= mult_q * g_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q        <= '0;
			mult_q       <= 9'd2;
			key_word_q   <= '0;
			bytes_left_q <= '0;
			chain_q      <= '0;
		end else begin
			if (cmd.seed_sum) begin
				lcg_q        <= seed_q[LCG_W-1:0];
				chain_q      <= chain_key_q;
				bytes_left_q <= '0;
			end
			if (cmd.seed_fold) begin
				mult_q <= seed_mod + 9'd2;
			end
			if (cmd.red_lcg) begin
				lcg_q <= lcg_prod_q + {add_key_q, 1'b1};
			end
			if (cmd.red_mult) begin
				mult_q <= mred;
			end
			if (cmd.make_word) begin
				key_word_q   <= word;
				bytes_left_q <= 3'd4;
			end
			if (cmd.emit) begin
				bytes_left_q <= bl_dec;
				chain_q      <= decrypt_q ? res : din_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_out_q <= res;
		end
	end

	assign status.need_refill = (bytes_left_q == 3'd0) || (bytes_left_q > 3'd4);
	assign status.red_is_one  = (mred == 9'd1);
	assign status.out_free    = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign data_out           = data_out_q;

endmodule

### hw/rtl/chained_keystream_byte_cipher.sv
`timescale 1ns / 1ps
// Chained keystream byte cipher.
// Input stream (s_*): s_tuser is the command, 0 = seed, 1 = data byte.
//   s_tdata carries the 64-bit seed and the data byte; the unused one is ignored.
// Output stream (m_*): one byte per data transaction, none per seed transaction.
// Config port: cfg_we/cfg_addr/cfg_wdata, 0 chain_key, 1 root_index, 2 mul_key,
//   3 add_key, 4 decrypt_mode. Write only while the block is idle.
// Steps, from acceptance to the next s_tready:
//   seed: byte sum, then mod-255 fold.
//   data byte from a full key word: byte step once the output register is free.
//   data byte that refills the key word (every 4th): the 45x8 LCG multiply and
//   9x9 modular multiply, each registered, then reduced; the mod-257 generator is
//   stepped again if it lands on 1. Then the word is rebuilt and the byte step runs.
// One item is in work at a time; s_tready is high only in the idle state.
// The result sits in an output register, so a new transaction is taken while
// m_tready is low; a second result waits until the first is taken.
// Reset clears generators to lcg 0, mult 2, empty key buffer, chain 0, and all
// config registers to 0.
module chained_keystream_byte_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] seed, [71:64] data_in
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_out
	input  logic        cfg_we,
	input  logic [ckbc_pkg::CFG_A_W-1:0] cfg_addr,
	input  logic [ckbc_pkg::ADD_W-1:0]   cfg_wdata
);
	import ckbc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	ckbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ckbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.seed      (s_tdata[SEED_W-1:0]),
		.data_in   (s_tdata[SEED_W +: BYTE_W]),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.data_out  (m_tdata)
	);

endmodule

### hw/rtl/ckbc_checker.sv
`timescale 1ns / 1ps
module ckbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);
	import ckbc_pkg::*;

	// held output stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction accepted back to back");

	// seed takes the sum and fold cycles
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_SEED |-> ##2 !s_tready)
		else $error("seed finished too early");

	// a new result is only produced while the input side is busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work in progress");

endmodule

bind chained_keystream_byte_cipher ckbc_checker u_ckbc_checker (.*);

### test/cipher_byte_checker.sv
`timescale 1ns / 1ps
// Watches the stream and config ports, predicts each output byte and
// compares it with what comes out on the master side.
module cipher_byte_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [71:0]                    s_tdata,   // [63:0] seed, [71:64] data_in
	input  logic                           s_tuser,   // [0] cmd
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,   // [7:0] data_out
	input  logic                           cfg_we,
	input  logic [ckbc_pkg::CFG_A_W-1:0]   cfg_addr,
	input  logic [ckbc_pkg::ADD_W-1:0]     cfg_wdata,
	output int                             fail_count,
	output int                             pending_count
);
	import ckbc_pkg::*;

	localparam int SHIFT_TOP   = 13;
	localparam int MAX_REPORTS = 10;

	// mirrored config
	logic [BYTE_W-1:0] chain_key  = '0;
	logic [ROOT_W-1:0] root_index = '0;
	logic [MULK_W-1:0] mul_key    = '0;
	logic [ADD_W-1:0]  add_key    = '0;
	logic              decrypt    = 1'b0;

	// generator state
	logic [LCG_W-1:0]  lcg_q   = '0;
	logic [MULT_W-1:0] mult_q  = MULT_W'(2);
	logic [WORD_W-1:0] word_q  = '0;
	logic [2:0]        left_q  = '0;
	logic [BYTE_W-1:0] chain_q = '0;

	logic [BYTE_W-1:0] expected_out_bytes [$];
	logic [BYTE_W-1:0] want;
	int                mismatches = 0;
	int                results_seen = 0;

	function automatic int unsigned root_pow(input logic [ROOT_W-1:0] idx);
		int unsigned g;
		g = 1;
		for (int i = 0; i <= 2 * idx; i++)
			g = (g * 3) % ROOT_MOD;
		return g;
	endfunction

	task automatic refill_key_word();
		logic [63:0] prod;
		logic [63:0] hi;
		logic [63:0] lo;
		int unsigned g;
		int unsigned m;
		int unsigned r;
		int unsigned s;
		prod = 64'(lcg_q) * 64'({mul_key, 2'b01}) + 64'({add_key, 1'b1});
		lcg_q = prod[LCG_W-1:0];
		g = root_pow(root_index);
		m = (mult_q * g) % ROOT_MOD;
		if (m == 1)
			m = (m * g) % ROOT_MOD;
		mult_q = MULT_W'(m);
		r = m % 32;
		s = SHIFT_TOP - m / 32;
		hi = (64'(lcg_q) >> s) >> r;
		lo = (64'(lcg_q) & ((64'd1 << s) - 64'd1)) << (WORD_W - s);
		word_q = WORD_W'(hi + lo);
		left_q = 3'd4;
	endtask

	task automatic predict_cipher_step(input logic cmd, input logic [SEED_W-1:0] seed,
			input logic [BYTE_W-1:0] din);
		logic [BYTE_W-1:0] ks;
		logic [BYTE_W-1:0] res;
		if (cmd == CMD_SEED) begin
			lcg_q   = seed[LCG_W-1:0];
			mult_q  = MULT_W'(seed % 64'd255 + 64'd2);
			chain_q = chain_key;
			left_q  = '0;
		end else begin
			if (left_q == 0)
				refill_key_word();
			left_q = left_q - 3'd1;
			ks = BYTE_W'(word_q >> (8 * left_q));
			if (decrypt) begin
				res = din + ks + chain_q;
				chain_q = res;
			end else begin
				res = din - (ks + chain_q);
				chain_q = din;
			end
			expected_out_bytes.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_key  = '0;
			root_index = '0;
			mul_key    = '0;
			add_key    = '0;
			decrypt    = 1'b0;
			lcg_q      = '0;
			mult_q     = MULT_W'(2);
			word_q     = '0;
			left_q     = '0;
			chain_q    = '0;
			expected_out_bytes.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			// output first: a byte can never leave on the edge its input enters
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_out_bytes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result %0d with nothing expected, data_out %02h",
							$time, results_seen, m_tdata);
				end else begin
					want = expected_out_bytes.pop_front();
					if (m_tdata !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: result %0d data_out expected %02h, actual %02h",
								$time, results_seen, want, m_tdata);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					CFG_CHAIN_KEY:    chain_key  = cfg_wdata[BYTE_W-1:0];
					CFG_ROOT_INDEX:   root_index = cfg_wdata[ROOT_W-1:0];
					CFG_MUL_KEY:      mul_key    = cfg_wdata[MULK_W-1:0];
					CFG_ADD_KEY:      add_key    = cfg_wdata[ADD_W-1:0];
					CFG_DECRYPT_MODE: decrypt    = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_cipher_step(s_tuser, s_tdata[SEED_W-1:0], s_tdata[SEED_W +: BYTE_W]);
			fail_count    <= mismatches;
			pending_count <= expected_out_bytes.size();
		end
	end

endmodule

### test/tb_chained_keystream_byte_cipher.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the chained keystream byte cipher.
// The checker instance next to the block does all prediction and comparison.
module tb_chained_keystream_byte_cipher ();
	import ckbc_pkg::*;

	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 12;      // time for a seed or a refill still in flight to finish
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 50;
	localparam int QUIET_FROM     = 8;       // phases from here on run without idling
	localparam int PRESSURE_PHASE = 3;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_LIMIT    = 20000;
	localparam logic [CFG_A_W-1:0] CFG_FIRST_UNUSED = CFG_DECRYPT_MODE + 1'b1;
	localparam logic [CFG_A_W-1:0] CFG_LAST_ADDR    = {CFG_A_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [71:0]          s_tdata;   // [63:0] seed, [71:64] data_in
	logic                 s_tuser;   // [0] cmd
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;   // [7:0] data_out
	logic                 cfg_we;
	logic [CFG_A_W-1:0]   cfg_addr;
	logic [ADD_W-1:0]     cfg_wdata;
	int                   fail_count;
	int                   pending;

	// idling controls and counters of the source and sink processes
	bit src_gaps  = 1'b1;
	bit sink_gaps = 1'b1;
	int stall_req = 0;
	int stall_len;
	int sent;
	int run_len;

	chained_keystream_byte_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	cipher_byte_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Seeds and data bytes: plenty of all-zero / all-one values, the rest random.
	function automatic logic [SEED_W-1:0] pick_seed();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Register value of a given width, biased to the two ends of its range.
	function automatic logic [ADD_W-1:0] pick_reg_value(input int width);
		logic [ADD_W-1:0] ones;
		ones = (44'd1 << width) - 44'd1;
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return ones;
			default: return ADD_W'({$urandom, $urandom}) & ones;
		endcase
	endfunction

	// One config write. Bits above the register width carry junk so that
	// the block has to ignore them.
	task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [ADD_W-1:0] value,
			input int width);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= ADD_W'(({$urandom, $urandom} << width) | 64'(value));
		@(posedge clk);
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// New random setting of every register, sometimes plus a write to a
	// hole in the register map, which must change nothing.
	task automatic shuffle_config();
		write_reg(CFG_CHAIN_KEY,    pick_reg_value(BYTE_W), BYTE_W);
		write_reg(CFG_ROOT_INDEX,   pick_reg_value(ROOT_W), ROOT_W);
		write_reg(CFG_MUL_KEY,      pick_reg_value(MULK_W), MULK_W);
		write_reg(CFG_ADD_KEY,      pick_reg_value(ADD_W),  ADD_W);
		write_reg(CFG_DECRYPT_MODE, pick_reg_value(1),      1);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_A_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_ADDR)),
				pick_reg_value(ADD_W), ADD_W);
		close_writes();
	endtask

	// Offer one transaction and hold it until the block takes it. The field
	// that the command does not use gets random content.
	task automatic send_item(input logic cmd, input logic [SEED_W-1:0] value);
		logic [SEED_W-1:0] seed_f;
		logic [BYTE_W-1:0] byte_f;
		seed_f = (cmd == CMD_SEED) ? value : {$urandom, $urandom};
		byte_f = (cmd == CMD_DATA) ? value[BYTE_W-1:0] : BYTE_W'($urandom);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {byte_f, seed_f};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering, wait for every predicted byte, then let a seed or a
	// refill still in flight finish before anything touches the config.
	task automatic wait_drained(input int limit);
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < limit);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sink: random back-pressure bursts, plus one long hold on request that
	// is counted here so the source keeps pushing and the block backs up.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_req != 0) begin
				m_tready <= 1'b0;
				stall_len = stall_req;
				stall_req = 0;
				repeat (stall_len) @(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Source and verdict
	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= CMD_SEED;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_CHAIN_KEY;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data with no seed yet: generators run from reset, chain starts at 0.
		// Five bytes so the second refill is reached too.
		send_item(CMD_DATA, 64'h00);
		send_item(CMD_DATA, 64'hFF);
		send_item(CMD_DATA, 64'h5A);
		send_item(CMD_DATA, 64'hA5);
		send_item(CMD_DATA, 64'h3C);
		wait_drained(DRAIN_LIMIT);

		// Every register at its top value, encrypting.
		write_reg(CFG_CHAIN_KEY,    '1, BYTE_W);
		write_reg(CFG_ROOT_INDEX,   '1, ROOT_W);
		write_reg(CFG_MUL_KEY,      '1, MULK_W);
		write_reg(CFG_ADD_KEY,      '1, ADD_W);
		write_reg(CFG_DECRYPT_MODE, '0, 1);
		close_writes();
		send_item(CMD_SEED, '0);
		send_item(CMD_DATA, 64'hFF);
		send_item(CMD_DATA, 64'h00);
		send_item(CMD_DATA, 64'hFF);
		send_item(CMD_DATA, 64'h00);
		send_item(CMD_DATA, 64'h80);
		send_item(CMD_SEED, '1);
		send_item(CMD_DATA, 64'h00);
		send_item(CMD_DATA, 64'h00);
		wait_drained(DRAIN_LIMIT);

		// Registers at zero, decrypting, plus a write to an unmapped index.
		write_reg(CFG_CHAIN_KEY,    '0, BYTE_W);
		write_reg(CFG_ROOT_INDEX,   '0, ROOT_W);
		write_reg(CFG_MUL_KEY,      '0, MULK_W);
		write_reg(CFG_ADD_KEY,      '0, ADD_W);
		write_reg(CFG_DECRYPT_MODE, '1, 1);
		write_reg(CFG_FIRST_UNUSED, '1, ADD_W);
		close_writes();
		// g = 3 here; seed 84 makes mult = 86, the inverse of 3, so the first
		// refill lands on 1 and the modular generator steps a second time
		send_item(CMD_SEED, 64'd84);
		repeat (4) send_item(CMD_DATA, pick_seed());
		// seed 254 gives mult = 256; the first refill steps it to 254 before the word is built
		send_item(CMD_SEED, 64'd254);
		send_item(CMD_DATA, 64'hFF);
		send_item(CMD_DATA, 64'h01);
		wait_drained(DRAIN_LIMIT);

		// Change mode and root in the middle of a message, no new seed.
		write_reg(CFG_DECRYPT_MODE, '0, 1);
		write_reg(CFG_ROOT_INDEX, 44'd64, ROOT_W);
		close_writes();
		repeat (3) send_item(CMD_DATA, pick_seed());

		// Random phases: mostly a seed followed by a run of data bytes, some
		// lone items. A phase may open with data, which continues the previous
		// message under the new setting.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained(DRAIN_LIMIT);
			shuffle_config();
			src_gaps  = (ph < QUIET_FROM);
			sink_gaps = (ph < QUIET_FROM);
			if (ph == PRESSURE_PHASE) begin
				src_gaps  = 1'b0;
				stall_req = HOLD_CYCLES;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(1'($urandom_range(0, 1)), pick_seed());
					sent++;
				end else begin
					send_item(CMD_SEED, pick_seed());
					run_len = $urandom_range(1, 16);
					repeat (run_len) send_item(CMD_DATA, pick_seed());
					sent += run_len + 1;
				end
			end
		end

		wait_drained(DRAIN_LIMIT);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/ckbc_pkg.sv
hw/rtl/ckbc_ctrl.sv
hw/rtl/ckbc_dp.sv
hw/rtl/chained_keystream_byte_cipher.sv
hw/rtl/ckbc_checker.sv
test/cipher_byte_checker.sv
test/tb_chained_keystream_byte_cipher.sv
